// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the stable sorted priority queue.
// No dependencies.
package spq_pkg;

  localparam int CAPACITY  = 16;
  localparam int PRIO_BITS = 8;
  localparam int VALUE_W   = 32;
  localparam int PRIO_W    = 8;
  localparam int FILL_W    = 5;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                 valid;
    logic [PRIO_BITS-1:0] prio;
    logic [VALUE_W-1:0]   value;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic                 ins;
    logic                 rem;
    logic [PRIO_BITS-1:0] prio;
    logic [VALUE_W-1:0]   value;
  } cmd_t;

endpackage

// ===== rtl/stable_sorted_priority_queue.sv =====
// The result strobe (done) is registered from accept and rises in the cycle after the item is accepted.
// Throughput: one item per cycle while busy is low; every cell of the chain shifts in the same cycle.
// busy is high only while rst is high and the cycle after; the receiver cannot stall.
// Reset (rst, synchronous) empties the queue; entry payloads are not cleared.
// Top level of the stable sorted priority queue; depends on spq_pkg and spq_cell.
module stable_sorted_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic signed [31:0] value_in,
  input  logic [7:0]  prio_in,
  output logic        done,
  output logic signed [31:0] value_out,
  output logic [7:0]  prio_out,
  output logic [1:0]  status,
  output logic [4:0]  fill_level
);
  import spq_pkg::*;

  entry_t            ent   [CAPACITY];
  logic              place [CAPACITY];
  cmd_t              cmd;
  logic              rst_q;
  logic              accept;
  logic              full;
  logic              empty;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CAPACITY-1:0] valid_vec;

  always_ff @(posedge clk) begin
    rst_q <= rst;
  end

  assign busy   = rst || rst_q;
  assign accept = start && !busy;
  assign full   = ent[CAPACITY-1].valid;
  assign empty  = !ent[0].valid;

  assign cmd.ins   = accept && (op == OP_INSERT) && !full;
  assign cmd.rem   = accept && (op == OP_REMOVE) && !empty;
  assign cmd.prio  = prio_in[PRIO_BITS-1:0];
  assign cmd.value = value_in;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      entry_t left_ent;
      entry_t right_ent;
      logic   left_pl;
      if (g == 0) begin : g_head
        assign left_ent = '0;
        assign left_pl  = 1'b0;
      end else begin : g_mid
        assign left_ent = ent[g-1];
        assign left_pl  = place[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign right_ent = '0;
      end else begin : g_body
        assign right_ent = ent[g+1];
      end
      assign valid_vec[g] = ent[g].valid;

      spq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .left       (left_ent),
        .left_place (left_pl),
        .right      (right_ent),
        .ent        (ent[g]),
        .place      (place[g])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_out  <= '0;
      prio_out   <= '0;
      status     <= ST_OK;
      fill_level <= FILL_W'(count_next);
      if (op == OP_INSERT) begin
        if (full) begin
          status <= ST_FULL;
        end
      end else if (empty) begin
        status <= ST_EMPTY;
      end else begin
        value_out <= ent[0].value;
        prio_out  <= PRIO_W'(ent[0].prio);
      end
    end
  end

`ifndef SYNTHESIS
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted item produced no result strobe");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("fill count disagrees with valid cells");

  a_full_level: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FULL) |-> (int'(fill_level) == (CAPACITY % 32)))
    else $error("dropped insert reported while not full");

  a_prefix: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec & (valid_vec + CAPACITY'(1))) == '0))
    else $error("valid cells do not form a prefix");
`endif

endmodule

// ===== rtl/spq_cell.sv =====
// One slot of the sorted queue: holds an entry, shifts right on insert, left on remove.
// Depends on spq_pkg.
module spq_cell (
  input  logic            clk,
  input  logic            rst,
  input  spq_pkg::cmd_t   cmd,
  input  spq_pkg::entry_t left,
  input  logic            left_place,
  input  spq_pkg::entry_t right,
  output spq_pkg::entry_t ent,
  output logic            place
);
  import spq_pkg::*;

  // new item belongs at or before this slot (ties go behind)
  assign place = !ent.valid || (ent.prio > cmd.prio);

  // payload is not cleared by reset; only the valid bit is
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (cmd.ins) begin
      if (left_place) begin
        ent.valid <= left.valid;
      end else if (place) begin
        ent.valid <= 1'b1;
      end
    end else if (cmd.rem) begin
      ent.valid <= right.valid;
    end

    if (cmd.ins) begin
      if (left_place) begin
        ent.prio  <= left.prio;
        ent.value <= left.value;
      end else if (place) begin
        ent.prio  <= cmd.prio;
        ent.value <= cmd.value;
      end
    end else if (cmd.rem) begin
      ent.prio  <= right.prio;
      ent.value <= right.value;
    end
  end

endmodule
